// ----- rtl/ssrc8_pkg.sv -----
`default_nettype none

package ssrc8_pkg;

    localparam int SLICE_BYTES_DEFAULT = 16;

    // Widest slice byte count over the legal slice sizes (up to 63 bytes)
    localparam int CNT_MAX_W = 6;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    localparam logic [7:0]  MARKER_RESET = 8'hFF;
    localparam logic [11:0] LENGTH_RESET = 12'd256;

    localparam logic REQ_MSG = 1'b0;
    localparam logic REQ_END = 1'b1;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic REG_MARKER = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef struct packed {
        logic                 bank;
        logic                 ok;
        logic [7:0]           sidx;
        logic [CNT_MAX_W-1:0] count;
    } cmd_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 8'h00)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/settings_slice_restore_crc8_core.sv -----
// Settings slice restore with CRC-8 check.
// Input queue side: push/full. A message item (req_type low) stores one byte with its
// default byte and folds it into an MSB-first CRC-8 (poly 0x31, init 0xFF); bytes past
// the slice size are dropped. An end item (req_type high) carries the stored checksum
// and slice index and closes the slice.
// Output queue side: empty/pop. For each held position whose global offset is below
// settings_length a restored byte beat comes out in ascending order, then one status
// beat with last high. checksum_ok tells whether the stored checksum matched.
// Configuration: cfg_valid/cfg_ready, always ready; index 0 marker_value, 1
// settings_length. Write only while no slice is being replayed.
// Flow: the input side takes a new item whenever full is low. Two slice banks in one RAM
// let the next slice load while the previous one replays. Replay picks up the command,
// then for each held byte reads the RAM and evaluates the read word, and ends with the
// status beat.
// full rises while both banks hold slices not yet replayed.
// Reset: CRC back to 0xFF, byte count to 0, queues empty; RAM contents are undefined.
// A stalled receiver holds the output beat and the replay waits on it.
`default_nettype none

module settings_slice_restore_crc8_core #(
    parameter int SLICE_BYTES = ssrc8_pkg::SLICE_BYTES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        req_type,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  default_byte,
    input  wire logic [7:0]  slice_index,
    output logic             empty,
    input  wire logic        pop,
    output logic             kind,
    output logic      [11:0] position,
    output logic      [7:0]  byte_value,
    output logic             checksum_ok,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_data
);

    localparam int IDX_W = (SLICE_BYTES > 1) ? $clog2(SLICE_BYTES) : 1;

    logic [7:0]      marker_reg;
    logic [11:0]     length_reg;
    logic            ram_we;
    logic [IDX_W:0]  ram_waddr;
    logic [15:0]     ram_wdata;
    logic            ram_re;
    logic [IDX_W:0]  ram_raddr;
    logic [15:0]     ram_rdata;
    logic            cmd_push;
    ssrc8_pkg::cmd_t cmd;
    ssrc8_pkg::cmd_t q_head;
    logic            q_empty;
    logic            q_pop;
    logic            done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= ssrc8_pkg::MARKER_RESET;
            length_reg <= ssrc8_pkg::LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssrc8_pkg::REG_MARKER: marker_reg <= cfg_data[7:0];
                ssrc8_pkg::REG_LENGTH: length_reg <= cfg_data;
                default:               length_reg <= length_reg;
            endcase
        end
    end

    ssrc8_front #(
        .SLICE_BYTES (SLICE_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .data_byte    (data_byte),
        .default_byte (default_byte),
        .slice_index  (slice_index),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .cmd_push     (cmd_push),
        .cmd          (cmd),
        .done         (done)
    );

    ssrc8_ram #(
        .WIDTH (16),
        .DEPTH (2 ** (IDX_W + 1))
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssrc8_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    ssrc8_back #(
        .SLICE_BYTES (SLICE_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_head),
        .q_pop           (q_pop),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .marker_value    (marker_reg),
        .settings_length (length_reg),
        .done            (done),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .position        (position),
        .byte_value      (byte_value),
        .checksum_ok     (checksum_ok),
        .last            (last)
    );

    // Loading and replay never touch the same bank
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr[IDX_W] != ram_raddr[IDX_W])
        else $error("store write and replay read hit the same bank");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("replay took a command from an empty queue");

    // With both banks held, at least one slice still waits in the queue
    a_full_queued: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_empty)
        else $error("front full with no queued slice");

endmodule

`default_nettype wire

// ----- rtl/ssrc8_ram.sv -----
`default_nettype none

module ssrc8_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ssrc8_queue.sv -----
`default_nettype none

module ssrc8_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ssrc8_pkg::cmd_t  push_data,
    input  wire logic             pop,
    output logic                  empty,
    output ssrc8_pkg::cmd_t       head
);

    ssrc8_pkg::cmd_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            do_pop;

    assign empty  = (fill_reg == 2'd0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ssrc8_front.sv -----
`default_nettype none

module ssrc8_front #(
    parameter int SLICE_BYTES = ssrc8_pkg::SLICE_BYTES_DEFAULT,
    localparam int IDX_W = (SLICE_BYTES > 1) ? $clog2(SLICE_BYTES) : 1,
    localparam int CNT_W = $clog2(SLICE_BYTES + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              req_type,
    input  wire logic [7:0]        data_byte,
    input  wire logic [7:0]        default_byte,
    input  wire logic [7:0]        slice_index,
    output logic                   ram_we,
    output logic      [IDX_W:0]    ram_waddr,
    output logic      [15:0]       ram_wdata,
    output logic                   cmd_push,
    output ssrc8_pkg::cmd_t        cmd,
    input  wire logic              done
);

    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             bank_reg;
    logic             bank_next;
    logic [1:0]       held_reg;
    logic [1:0]       held_next;
    logic             accept;

    // Both banks taken: one slice in the queue or being replayed, one more waiting
    assign full   = (held_reg == 2'd2);
    assign accept = push && !full;

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        bank_next  = bank_reg;
        ram_we     = 1'b0;
        ram_waddr  = {bank_reg, count_reg[IDX_W-1:0]};
        ram_wdata  = {data_byte, default_byte};
        cmd_push   = 1'b0;
        cmd.bank   = bank_reg;
        cmd.ok     = (data_byte == crc_reg);
        cmd.sidx   = slice_index;
        cmd.count  = ssrc8_pkg::CNT_MAX_W'(count_reg);
        if (accept)
        begin
            if (req_type == ssrc8_pkg::REQ_MSG)
            begin
                // drop bytes past the slice size
                if (count_reg < CNT_W'(SLICE_BYTES))
                begin
                    ram_we     = 1'b1;
                    crc_next   = ssrc8_pkg::crc8_byte(crc_reg, data_byte);
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                cmd_push   = 1'b1;
                crc_next   = ssrc8_pkg::CRC_INIT;
                count_next = '0;
                bank_next  = ~bank_reg;
            end
        end
        held_next = held_reg + {1'b0, cmd_push} - {1'b0, done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= ssrc8_pkg::CRC_INIT;
            count_reg <= '0;
            bank_reg  <= 1'b0;
            held_reg  <= 2'd0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            bank_reg  <= bank_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ssrc8_back.sv -----
`default_nettype none

module ssrc8_back #(
    parameter int SLICE_BYTES = ssrc8_pkg::SLICE_BYTES_DEFAULT,
    localparam int IDX_W = (SLICE_BYTES > 1) ? $clog2(SLICE_BYTES) : 1,
    localparam int CNT_W = $clog2(SLICE_BYTES + 1),
    localparam int POS_W = (8 + CNT_W > 12) ? 8 + CNT_W : 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire ssrc8_pkg::cmd_t  q_data,
    output logic                  q_pop,
    output logic                  ram_re,
    output logic      [IDX_W:0]   ram_raddr,
    input  wire logic [15:0]      ram_rdata,
    input  wire logic [7:0]       marker_value,
    input  wire logic [11:0]      settings_length,
    output logic                  done,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  kind,
    output logic      [11:0]      position,
    output logic      [7:0]       byte_value,
    output logic                  checksum_ok,
    output logic                  last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_EVAL   = 2'd2;
    localparam logic [1:0] ST_STATUS = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             bank_reg;
    logic             bank_next;
    logic             ok_reg;
    logic             ok_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;
    logic             in_range;
    logic             load_byte;
    logic             load_status;
    logic [7:0]       msg_byte;
    logic [7:0]       dflt_byte;
    logic [7:0]       restored;

    assign empty     = !out_valid_reg;
    assign slot_free = !out_valid_reg || pop;
    assign ram_raddr = {bank_reg, idx_reg[IDX_W-1:0]};
    assign msg_byte  = ram_rdata[15:8];
    assign dflt_byte = ram_rdata[7:0];
    assign in_range  = (pos_reg < POS_W'(settings_length));
    assign restored  = (!ok_reg || (msg_byte == marker_value)) ? dflt_byte : msg_byte;

    always_comb
    begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        ok_next     = ok_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        q_pop       = 1'b0;
        ram_re      = 1'b0;
        load_byte   = 1'b0;
        load_status = 1'b0;
        done        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    bank_next  = q_data.bank;
                    ok_next    = q_data.ok;
                    count_next = q_data.count[CNT_W-1:0];
                    idx_next   = '0;
                    pos_next   = POS_W'(q_data.sidx) * POS_W'(SLICE_BYTES);
                    state_next = (q_data.count == '0) ? ST_STATUS : ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // skip positions past the record, hold while the output beat is not yet taken
                if (!in_range || slot_free)
                begin
                    load_byte  = in_range;
                    idx_next   = idx_reg + 1'b1;
                    pos_next   = pos_reg + 1'b1;
                    state_next = ((idx_reg + 1'b1) == count_reg) ? ST_STATUS : ST_READ;
                end
            end
            ST_STATUS:
            begin
                if (slot_free)
                begin
                    load_status = 1'b1;
                    done        = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !pop) || load_byte || load_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            ok_reg        <= ok_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_byte)
        begin
            kind        <= ssrc8_pkg::KIND_BYTE;
            position    <= pos_reg[11:0];
            byte_value  <= restored;
            checksum_ok <= ok_reg;
            last        <= 1'b0;
        end
        else if (load_status)
        begin
            kind        <= ssrc8_pkg::KIND_STATUS;
            position    <= 12'd0;
            byte_value  <= 8'd0;
            checksum_ok <= ok_reg;
            last        <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_settings_slice_restore_crc8_core.sv -----
`default_nettype none

module tb_settings_slice_restore_crc8_core;

    localparam int SLICE_LEN   = ssrc8_pkg::SLICE_BYTES_DEFAULT;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        kind;
        logic [11:0] position;
        logic [7:0]  byte_value;
        logic        checksum_ok;
        logic        last;
    } restore_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        req_type = ssrc8_pkg::REQ_MSG;
    logic [7:0]  data_byte = 8'h00;
    logic [7:0]  default_byte = 8'h00;
    logic [7:0]  slice_index = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic        kind;
    logic [11:0] position;
    logic [7:0]  byte_value;
    logic        checksum_ok;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = ssrc8_pkg::REG_MARKER;
    logic [11:0] cfg_data = 12'h000;

    // Shadow of the block state
    logic [7:0]  held_msg [SLICE_LEN];
    logic [7:0]  held_dflt [SLICE_LEN];
    logic [7:0]  crc_acc = ssrc8_pkg::CRC_INIT;
    int          held_count = 0;
    logic [7:0]  marker_q = ssrc8_pkg::MARKER_RESET;
    logic [11:0] length_q = ssrc8_pkg::LENGTH_RESET;

    restore_beat_t restored_q [$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  slices_sent = 0;
    int  bad_crc_slices = 0;
    int  beats_checked = 0;
    int  full_waits = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    int  rx_stall_left = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    settings_slice_restore_crc8_core dut (.*);

    always #5 clk = ~clk;

    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[7] ^ b[k];
            c = {c[6:0], 1'b0} ^ (fb ? ssrc8_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic predict_restore(input logic req, input logic [7:0] data,
                                   input logic [7:0] dflt, input logic [7:0] sidx);
        logic       ok;
        logic [7:0] v;
        int         gi;
        if (req == ssrc8_pkg::REQ_MSG)
        begin
            // drop bytes past a full slice
            if (held_count < SLICE_LEN)
            begin
                held_msg[held_count]  = data;
                held_dflt[held_count] = dflt;
                crc_acc = crc8_fold(crc_acc, data);
                held_count++;
            end
        end
        else
        begin
            ok = (data == crc_acc);
            for (int i = 0; i < held_count; i++)
            begin
                gi = int'(sidx) * SLICE_LEN + i;
                if (gi < int'(length_q))
                begin
                    v = (!ok || held_msg[i] == marker_q) ? held_dflt[i] : held_msg[i];
                    restored_q.push_back('{ssrc8_pkg::KIND_BYTE, 12'(gi), v, ok, 1'b0});
                end
            end
            restored_q.push_back('{ssrc8_pkg::KIND_STATUS, 12'h000, 8'h00, ok, 1'b1});
            if (!ok) bad_crc_slices++;
            crc_acc = ssrc8_pkg::CRC_INIT;
            held_count = 0;
        end
    endtask

    task automatic send_item(input logic req, input logic [7:0] data, input logic [7:0] dflt,
                             input logic [7:0] sidx, input int gap);
        logic accepted;
        @(negedge clk);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type     = req;
        data_byte    = data;
        default_byte = dflt;
        slice_index  = sidx;
        push         = 1'b1;
        do
        begin
            @(posedge clk);
            accepted = !full;
            if (!accepted) full_waits++;
        end while (!accepted);
        items_sent++;
        predict_restore(req, data, dflt, sidx);
    endtask

    task automatic send_slice(input int nbytes, input logic [7:0] sidx, input bit good_crc);
        logic [7:0] data;
        for (int i = 0; i < nbytes; i++)
        begin
            data = ($urandom_range(0, 99) < 20) ? marker_q : 8'($urandom);
            send_item(ssrc8_pkg::REQ_MSG, data, 8'($urandom), 8'($urandom), pick_gap());
        end
        data = good_crc ? crc_acc : 8'($urandom);
        send_item(ssrc8_pkg::REQ_END, data, 8'($urandom), sidx, pick_gap());
        slices_sent++;
    endtask

    task automatic run_random_phase(input int n_items, input int idx_lo, input int idx_hi,
                                    input int bad_pct);
        int start;
        int r;
        int nbytes;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 8) nbytes = 0;
            else if (r < 18) nbytes = $urandom_range(SLICE_LEN + 1, SLICE_LEN + 4);
            else nbytes = $urandom_range(1, SLICE_LEN);
            send_slice(nbytes, 8'($urandom_range(idx_lo, idx_hi)),
                       $urandom_range(0, 99) >= bad_pct);
        end
    endtask

    // Lower push, let every expected beat arrive, then let the replay settle
    task automatic wait_drain();
        @(negedge clk);
        push = 1'b0;
        while (restored_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == ssrc8_pkg::REG_MARKER) marker_q = val[7:0];
        else length_q = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [11:0] exp_v,
                               input logic [11:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Result side: random pop with short and long stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop = 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            pop = 1'b0;
            rx_stall_left--;
        end
        else
        begin
            pop = 1'b1;
            if (!rx_steady) rx_stall_left = pick_stall();
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0) hold_left--;
    end

    always @(posedge clk)
    begin
        restore_beat_t exp_beat;
        if (rst_n && pop && !empty)
        begin
            if (restored_q.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0h position %0h",
                       kind, position);
                fail_count++;
            end
            else
            begin
                exp_beat = restored_q.pop_front();
                check_field("kind", 12'(exp_beat.kind), 12'(kind));
                check_field("position", exp_beat.position, position);
                check_field("byte_value", 12'(exp_beat.byte_value), 12'(byte_value));
                check_field("checksum_ok", 12'(exp_beat.checksum_ok), 12'(checksum_ok));
                check_field("last", 12'(exp_beat.last), 12'(last));
                beats_checked++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic test_empty_slice();
        send_item(ssrc8_pkg::REQ_END, crc_acc, 8'h00, 8'h00, pick_gap());
        slices_sent++;
    endtask

    task automatic test_overflow_slice();
        logic [7:0] data;
        logic [7:0] dflt;
        for (int i = 0; i <= SLICE_LEN; i++)
        begin
            data = (i == 0) ? 8'h00 : (i == 1) ? marker_q : 8'($urandom);
            dflt = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom);
            send_item(ssrc8_pkg::REQ_MSG, data, dflt, 8'($urandom), pick_gap());
        end
        send_item(ssrc8_pkg::REQ_END, crc_acc, 8'hFF, 8'd15, pick_gap());
        slices_sent++;
    endtask

    task automatic test_bad_checksum();
        for (int i = 0; i < 3; i++)
            send_item(ssrc8_pkg::REQ_MSG, 8'($urandom), 8'($urandom), 8'($urandom),
                      pick_gap());
        send_item(ssrc8_pkg::REQ_END, ~crc_acc, 8'h00, 8'd3, pick_gap());
        slices_sent++;
    endtask

    task automatic test_beyond_record();
        for (int i = 0; i < 2; i++)
            send_item(ssrc8_pkg::REQ_MSG, 8'($urandom), 8'($urandom), 8'h00, pick_gap());
        send_item(ssrc8_pkg::REQ_END, crc_acc, 8'h00, 8'hFF, pick_gap());
        slices_sent++;
    endtask

    task automatic test_marker_full_record();
        wait_drain();
        write_reg(ssrc8_pkg::REG_MARKER, {4'hA, 8'h00});
        write_reg(ssrc8_pkg::REG_LENGTH, 12'hFFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random_phase(20, 0, 255, 25);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_random_phase(25, 240, 255, 25);
    endtask

    task automatic test_truncated_record();
        wait_drain();
        write_reg(ssrc8_pkg::REG_MARKER, 12'($urandom));
        write_reg(ssrc8_pkg::REG_LENGTH, 12'($urandom_range(17, 120)));
        run_random_phase(40, 0, 8, 25);
    endtask

    task automatic test_zero_length();
        wait_drain();
        write_reg(ssrc8_pkg::REG_LENGTH, 12'h000);
        run_random_phase(15, 0, 255, 30);
    endtask

    task automatic test_backpressure();
        wait_drain();
        write_reg(ssrc8_pkg::REG_MARKER, 12'($urandom));
        write_reg(ssrc8_pkg::REG_LENGTH, 12'($urandom_range(64, 4095)));
        @(negedge clk);
        hold_left = 400;
        // offer whole slices back to back so both banks fill and full rises
        tx_steady = 1'b1;
        for (int s = 0; s < 4; s++)
            send_slice(SLICE_LEN, 8'(s), 1'b1);
        tx_steady = 1'b0;
        wait_drain();
    endtask

    task automatic test_reset_settings();
        wait_drain();
        write_reg(ssrc8_pkg::REG_MARKER, {4'h5, ssrc8_pkg::MARKER_RESET});
        write_reg(ssrc8_pkg::REG_LENGTH, ssrc8_pkg::LENGTH_RESET);
        run_random_phase(35, 12, 20, 20);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_empty_slice();
        test_overflow_slice();
        test_bad_checksum();
        test_beyond_record();
        test_marker_full_record();
        test_truncated_record();
        test_zero_length();
        test_backpressure();
        test_reset_settings();
        wait_drain();

        $display("Checked %0d result beats from %0d slices (%0d with a bad checksum), %0d items.",
                 beats_checked, slices_sent, bad_crc_slices, items_sent);
        $display("Input held off by full on %0d cycles across marker and length settings.",
                 full_waits);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/ssrc8_pkg.sv
rtl/ssrc8_ram.sv
rtl/ssrc8_queue.sv
rtl/ssrc8_front.sv
rtl/ssrc8_back.sv
rtl/settings_slice_restore_crc8_core.sv
tb/tb_settings_slice_restore_crc8_core.sv
